// File: rtl/sdtp_pkg.sv
// Shared constants for the step-distance block.
package sdtp_pkg;
  localparam int COORD_BITS_DEF = 13;
  localparam int STEP_BITS = 15;
  localparam int OUT_BITS = 16;
endpackage

// File: rtl/sdtp_sqrt_stage.sv
// One restoring digit step of the pipelined floor square root, with payload carry.
module sdtp_sqrt_stage #(
  parameter int RW = 28,
  parameter int QW = 14,
  parameter int K  = 0,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          v_in,
  input  logic [RW-1:0] rem_in,
  input  logic [QW-1:0] root_in,
  input  logic [RW-1:0] val_in,
  input  logic [PW-1:0] pay_in,
  output logic          v_out,
  output logic [RW-1:0] rem_out,
  output logic [QW-1:0] root_out,
  output logic [RW-1:0] val_out,
  output logic [PW-1:0] pay_out
);
  // root bit K decided: rem' = rem*4 + next two bits; trial = root*4+1
  logic [RW+1:0] shifted;
  logic [RW+1:0] trial;
  logic          take;

  assign shifted = {rem_in, val_in[2*K+1 -: 2]};
  assign trial   = {{(RW+2-QW-2){1'b0}}, root_in, 2'b01};
  assign take    = shifted >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= take ? RW'(shifted - trial) : RW'(shifted);
      root_out <= {root_in[QW-2:0], take};
      val_out  <= val_in;
      pay_out  <= pay_in;
    end
  end
endmodule

// File: rtl/sdtp_div_stage.sv
// One restoring quotient bit step for both axis dividers, with payload carry.
module sdtp_div_stage #(
  parameter int NW = 28,
  parameter int DW = 14,
  parameter int K  = 0,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          v_in,
  input  logic [DW-1:0] den,
  input  logic [DW:0]   ra_in,
  input  logic [NW-1:0] qa_in,
  input  logic [DW:0]   rb_in,
  input  logic [NW-1:0] qb_in,
  input  logic [PW-1:0] pay_in,
  output logic          v_out,
  output logic [DW-1:0] den_out,
  output logic [DW:0]   ra_out,
  output logic [NW-1:0] qa_out,
  output logic [DW:0]   rb_out,
  output logic [NW-1:0] qb_out,
  output logic [PW-1:0] pay_out
);
  logic [DW+1:0] sa, sb, dd;
  logic [NW-1:0] qa_nxt, qb_nxt;
  assign sa = {ra_in, qa_in[K]};
  assign sb = {rb_in, qb_in[K]};
  assign dd = {2'b00, den};

  // quotient bit K replaces the numerator bit just consumed
  always_comb begin
    qa_nxt    = qa_in;
    qa_nxt[K] = (sa >= dd);
    qb_nxt    = qb_in;
    qb_nxt[K] = (sb >= dd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_out   <= den;
      ra_out    <= (sa >= dd) ? (DW+1)'(sa - dd) : sa[DW:0];
      rb_out    <= (sb >= dd) ? (DW+1)'(sb - dd) : sb[DW:0];
      qa_out    <= qa_nxt;
      qb_out    <= qb_nxt;
      pay_out   <= pay_in;
    end
  end
endmodule

// File: rtl/step_distance_toward_point.sv
// Top level: step a signed distance from a start point toward a target point.
// Pipeline: three front stages, the root stages, the divide stages
// and the output register.
// Throughput: one transaction per cycle; the whole pipeline advances when the
// output register is free or being taken (in_tready = !out_tvalid | out_tready).
// Reset (rst_n low, synchronous) clears all valid bits; payload is not reset.
module step_distance_toward_point
  import sdtp_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // start_x, start_y, target_x, target_y, step_length (low bit up), zero fill
  input  logic [((4*COORD_BITS+STEP_BITS+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // result_x, result_y, points_coincide (low bit up), zero fill
  output logic [39:0] out_tdata
);
  localparam int CW = COORD_BITS;
  localparam int SW = STEP_BITS;
  localparam int DW = CW + 1;            // |dx|, root width
  localparam int RW = 2 * DW;            // squared sum width
  localparam int NW = SW + CW;           // |step*d| width
  // payload: sx, sy, step, sign_a, sign_b
  localparam int PW = 2 * CW + SW + 2;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Stage 1: differences
  logic          v1;
  logic [CW-1:0] sx1, sy1;
  logic [SW-1:0] st1;
  logic signed [CW:0] dx1, dy1;
  logic [CW-1:0] isx, isy, itx, ity;
  assign isx = in_tdata[CW-1:0];
  assign isy = in_tdata[2*CW-1:CW];
  assign itx = in_tdata[3*CW-1:2*CW];
  assign ity = in_tdata[4*CW-1:3*CW];

  always_ff @(posedge clk) begin
    if (!rst_n) v1 <= 1'b0;
    else if (en) v1 <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sx1 <= isx;
      sy1 <= isy;
      st1 <= in_tdata[4*CW+SW-1:4*CW];
      dx1 <= $signed({1'b0, itx}) - $signed({1'b0, isx});
      dy1 <= $signed({1'b0, ity}) - $signed({1'b0, isy});
    end
  end

  // Stage 2: squares and products of magnitudes
  logic          v2;
  logic [CW-1:0] sx2, sy2;
  logic [SW-1:0] st2;
  logic [RW-1:0] dx2sq, dy2sq;
  logic [NW-1:0] pa2, pb2;
  logic          sa2, sb2;
  logic [DW-1:0] ax1, ay1;
  logic [SW-1:0] as1;
  assign ax1 = dx1[CW] ? DW'(-dx1) : DW'(dx1);
  assign ay1 = dy1[CW] ? DW'(-dy1) : DW'(dy1);
  assign as1 = st1[SW-1] ? SW'(-st1) : st1;

  always_ff @(posedge clk) begin
    if (!rst_n) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sx2   <= sx1;
      sy2   <= sy1;
      st2   <= st1;
      dx2sq <= RW'(ax1 * ax1);
      dy2sq <= RW'(ay1 * ay1);
      pa2   <= NW'(as1 * ax1[CW-1:0]);
      pb2   <= NW'(as1 * ay1[CW-1:0]);
      sa2   <= st1[SW-1] ^ dx1[CW];
      sb2   <= st1[SW-1] ^ dy1[CW];
    end
  end

  // Stage 3: sum of squares
  logic          v3;
  logic [RW-1:0] sq3;
  logic [PW-1:0] pay3;
  logic [NW-1:0] pa3, pb3;
  always_ff @(posedge clk) begin
    if (!rst_n) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sq3  <= dx2sq + dy2sq;
      pay3 <= {sb2, sa2, st2, sy2, sx2};
      pa3  <= pa2;
      pb3  <= pb2;
    end
  end

  // Root pipeline; products ride in the payload
  localparam int XW = PW + 2 * NW;
  logic          rv [DW+1];
  logic [RW-1:0] rr [DW+1];
  logic [DW-1:0] rq [DW+1];
  logic [RW-1:0] rval [DW+1];
  logic [XW-1:0] rp [DW+1];
  assign rv[0]   = v3;
  assign rr[0]   = '0;
  assign rq[0]   = '0;
  assign rval[0] = sq3;
  assign rp[0]   = {pb3, pa3, pay3};

  for (genvar i = 0; i < DW; i++) begin : g_root
    sdtp_sqrt_stage #(.RW(RW), .QW(DW), .K(DW-1-i), .PW(XW)) u_stage (
      .clk(clk), .rst_n(rst_n), .en(en),
      .v_in(rv[i]), .rem_in(rr[i]), .root_in(rq[i]), .val_in(rval[i]), .pay_in(rp[i]),
      .v_out(rv[i+1]), .rem_out(rr[i+1]), .root_out(rq[i+1]), .val_out(rval[i+1]),
      .pay_out(rp[i+1])
    );
  end

  // Divide pipeline: quotient bits MSB first, overwriting the numerator
  logic          dv [NW+1];
  logic [DW-1:0] dd [NW+1];
  logic [DW:0]   dra [NW+1], drb [NW+1];
  logic [NW-1:0] dqa [NW+1], dqb [NW+1];
  logic [PW-1:0] dp [NW+1];
  assign dv[0]  = rv[DW];
  assign dd[0]  = rq[DW];
  assign dra[0] = '0;
  assign drb[0] = '0;
  assign dp[0]  = rp[DW][PW-1:0];
  assign dqa[0] = rp[DW][PW+NW-1:PW];
  assign dqb[0] = rp[DW][XW-1:PW+NW];

  for (genvar j = 0; j < NW; j++) begin : g_div
    sdtp_div_stage #(.NW(NW), .DW(DW), .K(NW-1-j), .PW(PW)) u_stage (
      .clk(clk), .rst_n(rst_n), .en(en), .v_in(dv[j]), .den(dd[j]),
      .ra_in(dra[j]), .qa_in(dqa[j]), .rb_in(drb[j]), .qb_in(dqb[j]), .pay_in(dp[j]),
      .v_out(dv[j+1]), .den_out(dd[j+1]), .ra_out(dra[j+1]), .qa_out(dqa[j+1]),
      .rb_out(drb[j+1]), .qb_out(dqb[j+1]), .pay_out(dp[j+1])
    );
  end

  // Final: apply signs, add start, register output
  logic [CW-1:0]       fsx, fsy;
  logic                fsa, fsb, coin;
  logic [OUT_BITS-1:0] offa, offb, rx, ry;
  assign fsx  = dp[NW][CW-1:0];
  assign fsy  = dp[NW][2*CW-1:CW];
  assign fsa  = dp[NW][PW-2];
  assign fsb  = dp[NW][PW-1];
  assign coin = (dd[NW] == '0);
  assign offa = fsa ? OUT_BITS'(-dqa[NW]) : OUT_BITS'(dqa[NW]);
  assign offb = fsb ? OUT_BITS'(-dqb[NW]) : OUT_BITS'(dqb[NW]);
  assign rx   = coin ? OUT_BITS'(fsx) : OUT_BITS'(OUT_BITS'(fsx) + offa);
  assign ry   = coin ? OUT_BITS'(fsy) : OUT_BITS'(OUT_BITS'(fsy) + offb);

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (en) out_tvalid <= dv[NW];
  end
  always_ff @(posedge clk) begin
    if (en) out_tdata <= {7'd0, coin, ry, rx};
  end
endmodule

// File: bench/tb_top.sv
// Testbench for step_distance_toward_point: directed and random stepping queries.
`timescale 1ns / 100ps

module tb_top;
  import sdtp_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int IN_W = ((4*CB+STEP_BITS+7)/8)*8;
  localparam int LAT = 4 + (CB+1) + (STEP_BITS+CB);

  // packed from the top down: coincide above ry above rx, as on out_tdata
  typedef struct packed {
    logic                       coincide;
    logic signed [OUT_BITS-1:0] ry;
    logic signed [OUT_BITS-1:0] rx;
  } step_res_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  // start_x, start_y, target_x, target_y, step_length (low bit up), zero fill
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  // result_x, result_y, points_coincide (low bit up), zero fill
  logic [39:0] out_tdata;

  step_res_t expected_steps[$];
  int errors = 0;
  int sent = 0;
  int got = 0;
  int n_coincide = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 0;

  step_distance_toward_point dut (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Exact floor square root, digit by digit.
  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned rem, root, b;
    rem = v;
    root = 0;
    b = 64'd1 << 62;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic step_res_t predict_step(
      bit [CB-1:0] sx, bit [CB-1:0] sy, bit [CB-1:0] tx, bit [CB-1:0] ty,
      bit signed [STEP_BITS-1:0] st);
    longint dx, dy, len, s;
    step_res_t r;
    s = st;
    dx = longint'(tx) - longint'(sx);
    dy = longint'(ty) - longint'(sy);
    len = longint'(isqrt(dx*dx + dy*dy));
    r.coincide = (len == 0);
    if (len == 0) begin
      r.rx = OUT_BITS'(sx);
      r.ry = OUT_BITS'(sy);
    end else begin
      // SV division on signed longint truncates toward zero like C
      r.rx = OUT_BITS'(longint'(sx) + (s*dx)/len);
      r.ry = OUT_BITS'(longint'(sy) + (s*dy)/len);
    end
    return r;
  endfunction

  // Send one query; prediction queued at acceptance. Valid stays up on return
  // so the next query can follow back to back.
  task automatic send_query(bit [CB-1:0] sx, bit [CB-1:0] sy, bit [CB-1:0] tx,
                            bit [CB-1:0] ty, bit [STEP_BITS-1:0] st);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata <= IN_W'({st, ty, tx, sy, sx});
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_steps.push_back(predict_step(sx, sy, tx, ty, st));
    sent++;
    @(negedge clk);
  endtask

  task automatic send_random(int n);
    bit [CB-1:0] sx, sy, tx, ty;
    repeat (n) begin
      sx = CB'($urandom);
      sy = CB'($urandom);
      case ($urandom_range(3))
        0: begin
          tx = CB'(sx + $urandom_range(8) - 4);
          ty = CB'(sy + $urandom_range(8) - 4);
        end
        1: begin tx = sx; ty = CB'($urandom); end
        default: begin tx = CB'($urandom); ty = CB'($urandom); end
      endcase
      send_query(sx, sy, tx, ty, STEP_BITS'($urandom));
    end
    in_tvalid <= 1'b0;
  endtask

  task automatic drain();
    int guard = 0;
    do begin
      @(negedge clk);
      guard++;
    end while (expected_steps.size() != 0 && guard < 100000);
  endtask

  // Receiver ready, with random stalls and an optional long hold.
  always @(negedge clk) begin
    if (recv_hold) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result checker.
  always @(posedge clk) begin
    step_res_t act, exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      act = out_tdata[2*OUT_BITS:0];
      got++;
      if (expected_steps.size() == 0) begin
        $display("%0t: unexpected transaction %h", $time, act);
        errors++;
      end else begin
        exp_r = expected_steps.pop_front();
        if (exp_r.coincide) n_coincide++;
        if (act.rx !== exp_r.rx || act.ry !== exp_r.ry ||
            act.coincide !== exp_r.coincide) begin
          $display("%0t: mismatch exp x=%0d y=%0d c=%0b got x=%0d y=%0d c=%0b",
                   $time, exp_r.rx, exp_r.ry, exp_r.coincide,
                   act.rx, act.ry, act.coincide);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    localparam bit [CB-1:0] MX = '1;
    send_query(0, 0, 0, 0, 15'sd100);            // coincident at origin
    send_query(MX, MX, MX, MX, 15'h4000);        // coincident at max
    send_query(0, 0, MX, MX, 15'h3FFF);          // max positive step
    send_query(0, 0, MX, MX, 15'h4000);          // most negative step
    send_query(MX, MX, 0, 0, 15'h3FFF);
    send_query(MX, 0, 0, MX, 15'h4000);
    send_query(0, MX, MX, 0, 15'h7FFF);          // step -1
    send_query(100, 100, 103, 104, 15'd5);       // exact length
    send_query(100, 100, 101, 101, 15'd7);       // length floors
    send_query(50, 50, 50, 60, 15'h7FF6);        // negative, axis-aligned
    send_query(50, 50, 49, 50, 15'd0);           // zero step
    send_query(10, 20, 13, 24, 15'h7FFD);        // truncation toward zero
    send_query(0, MX, 0, 0, 15'h3FFF);
    send_query(MX, 0, 0, 0, 15'h4000);
    in_tvalid <= 1'b0;
    drain();
  endtask

  task automatic test_slow_receiver();
    send_idle_pct = 13; recv_idle_pct = 80;
    send_random(250);
    drain();
  endtask

  task automatic test_slow_sender();
    send_idle_pct = 80; recv_idle_pct = 13;
    send_random(200);
    drain();
  endtask

  task automatic test_back_pressure();
    send_idle_pct = 0; recv_idle_pct = 0;
    recv_hold = 1;
    fork
      begin
        repeat (3*LAT) @(negedge clk);
        recv_hold = 0;
      end
      send_random(2*LAT);
    join
    drain();   // sender pauses until everything has come back
    send_random(220);
    drain();
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    out_tready = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    test_directed();
    test_slow_receiver();
    test_slow_sender();
    test_back_pressure();
    repeat (LAT + 10) @(posedge clk);
    $display("Covered %0d queries (%0d coincident) with directed extremes,", sent, n_coincide);
    $display("random stalls on both sides and a long output hold; %0d results.", got);
    if (errors == 0 && expected_steps.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
